[rtl/utf8sd_pkg.sv]
// Shared types and constants for the six-byte UTF-8 decoder.
// Depends on nothing; utf8sd_step and the top level import it.
package utf8sd_pkg;

  localparam logic [2:0] ST_CHAR      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL   = 3'd1;
  localparam logic [2:0] ST_FINAL_NUL = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;

  localparam logic [7:0] MASK_CONT = 8'hc0;
  localparam logic [7:0] PAT_CONT  = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'he0;
  localparam logic [7:0] PAT_LEAD2  = 8'hc0;
  localparam logic [7:0] MASK_LEAD3 = 8'hf0;
  localparam logic [7:0] PAT_LEAD3  = 8'he0;
  localparam logic [7:0] MASK_LEAD4 = 8'hf8;
  localparam logic [7:0] PAT_LEAD4  = 8'hf0;
  localparam logic [7:0] MASK_LEAD5 = 8'hfc;
  localparam logic [7:0] PAT_LEAD5  = 8'hf8;
  localparam logic [7:0] MASK_LEAD6 = 8'hfe;
  localparam logic [7:0] PAT_LEAD6  = 8'hfc;

  localparam logic [7:0] BITS_CONT  = 8'h3f;
  localparam logic [7:0] BITS_LEAD2 = 8'h1f;
  localparam logic [7:0] BITS_LEAD3 = 8'h0f;
  localparam logic [7:0] BITS_LEAD4 = 8'h07;
  localparam logic [7:0] BITS_LEAD5 = 8'h03;
  localparam logic [7:0] BITS_LEAD6 = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  status;
    logic [31:0] chars_written;
    logic        buffer_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  pending;
    logic [30:0] acc;
    logic        halted;
  } dec_state_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

[rtl/utf8sd_stream_if.sv]
// Valid/ready stream interface with a typed payload.
// Depends on nothing; the payload type is given per instance.
interface utf8sd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/utf8sd_step.sv]
// One decode step: next decoder state, next count and the result word.
// Depends on utf8sd_pkg.
module utf8sd_step
  import utf8sd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  in_item_t               in_item,
  input  dec_state_t             state_cur,
  input  logic [COUNT_WIDTH-1:0] cnt_cur,
  input  logic [31:0]            max_chars,
  output dec_state_t             state_nxt,
  output logic [COUNT_WIDTH-1:0] cnt_nxt,
  output step_res_t              res
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       inc_ext;
  logic [CMP_W-1:0]       max_ext;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   limit_cur;
  logic                   limit_inc;
  logic [7:0]             b;
  logic                   last;
  logic                   bad;
  logic [2:0]             pend_w;
  logic [30:0]            acc_w;

  assign b         = in_item.data_byte;
  assign last      = in_item.end_of_buffer;
  assign cnt_inc   = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign cnt_ext   = CMP_W'(cnt_cur);
  assign inc_ext   = CMP_W'(cnt_inc);
  assign max_ext   = CMP_W'(max_chars);
  assign limit_cur = (max_chars != 32'd0) && (cnt_ext >= max_ext);
  assign limit_inc = (max_chars != 32'd0) && (inc_ext >= max_ext);

  always_comb begin
    bad    = 1'b0;
    pend_w = 3'd0;
    acc_w  = 31'd0;
    if (state_cur.pending == 3'd0) begin
      if (b[7] == 1'b0) begin
        acc_w = 31'(b);
      end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
        acc_w  = 31'(b & BITS_LEAD2);
        pend_w = 3'd1;
      end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
        acc_w  = 31'(b & BITS_LEAD3);
        pend_w = 3'd2;
      end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
        acc_w  = 31'(b & BITS_LEAD4);
        pend_w = 3'd3;
      end else if ((b & MASK_LEAD5) == PAT_LEAD5) begin
        acc_w  = 31'(b & BITS_LEAD5);
        pend_w = 3'd4;
      end else if ((b & MASK_LEAD6) == PAT_LEAD6) begin
        acc_w  = 31'(b & BITS_LEAD6);
        pend_w = 3'd5;
      end else begin
        bad = 1'b1;
      end
    end else begin
      bad    = ((b & MASK_CONT) != PAT_CONT);
      acc_w  = {state_cur.acc[24:0], b[5:0] & BITS_CONT[5:0]};
      pend_w = state_cur.pending - 3'd1;
    end
  end

  always_comb begin
    state_nxt                   = state_cur;
    cnt_nxt                     = cnt_cur;
    res.emit                    = 1'b0;
    res.item.code_point         = 31'd0;
    res.item.status             = ST_CHAR;
    res.item.chars_written      = cnt_ext[31:0];
    res.item.buffer_done        = 1'b1;
    if (state_cur.halted) begin
      res.item.buffer_done = 1'b0;
    end else if ((state_cur.pending == 3'd0) && limit_cur) begin
      res.emit         = 1'b1;
      res.item.status  = ST_LIMIT;
      state_nxt.halted = 1'b1;
    end else if (bad) begin
      res.emit         = 1'b1;
      res.item.status  = ST_ILLEGAL;
      state_nxt.halted = 1'b1;
    end else if (pend_w != 3'd0) begin
      state_nxt.pending = pend_w;
      state_nxt.acc     = acc_w;
      res.emit          = last;
      res.item.status   = ST_TRUNCATED;
    end else begin
      state_nxt.pending = 3'd0;
      state_nxt.acc     = 31'd0;
      res.emit          = 1'b1;
      if ((acc_w == 31'd0) && last) begin
        res.item.status = ST_FINAL_NUL;
      end else begin
        cnt_nxt                = cnt_inc;
        res.item.code_point    = acc_w;
        res.item.chars_written = inc_ext[31:0];
        if (limit_inc) begin
          res.item.status  = ST_LIMIT;
          state_nxt.halted = 1'b1;
        end else begin
          res.item.buffer_done = last;
        end
      end
    end
    if (last) begin
      state_nxt = '0;
      cnt_nxt   = '0;
    end
  end

endmodule

[rtl/utf8_six_byte_decoder.sv]
// Top level of the six-byte UTF-8 decoder: input register, decode step, result register.
// Depends on utf8sd_pkg, utf8sd_stream_if and utf8sd_step.
//
//   channel   direction  payload                                          handshake
//   in_ch     in         data_byte, end_of_buffer                         valid/ready
//   out_ch    out        code_point, status, chars_written, buffer_done   valid/ready
//   cfg       in         max_chars                                        cfg_we, no wait
//
// One word per cycle sustained while out_ch does not stall.
// Decoder state updates in the same cycle as the result register loads.
// rst_n clears state, count, max_chars and both valid flags.
// A stalled result holds the decode stage; the input register then fills only if empty.
module utf8_six_byte_decoder
  import utf8sd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  utf8sd_stream_if.sink   in_ch,
  utf8sd_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  in_item_t               in_r;
  logic                   in_valid_r;
  dec_state_t             state_r;
  dec_state_t             state_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic [31:0]            max_chars_r;
  out_item_t              out_r;
  logic                   out_valid_r;
  step_res_t              step_res;
  logic                   advance;
  logic                   in_take;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_r;

  utf8sd_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .in_item   (in_r),
    .state_cur (state_r),
    .cnt_cur   (cnt_r),
    .max_chars (max_chars_r),
    .state_nxt (state_nxt),
    .cnt_nxt   (cnt_nxt),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      cnt_r       <= '0;
      max_chars_r <= 32'd0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= step_res.emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        max_chars_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_ch.payload;
    end
    if (advance && step_res.emit) begin
      out_r <= step_res.item;
    end
  end

endmodule
